// ===== sv/sfr_pkg.sv =====
// sfr_pkg: shared types and constants for the stream find-and-replace block.
// Holds the transaction payload structs, register indexes and the
// controller/datapath command and status bundles. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CAP_W      = 17;
    localparam int CNT13_W    = 13;
    localparam int REPL_MAX   = 8;

    // Capacity reset value
    localparam logic [CAP_W-1:0] MAX_TEXT = 17'd8192;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY          = 3'd4;

    // Input transaction
    typedef struct packed {
        logic [7:0]         data_byte;
        logic               last;
        logic [CNT13_W-1:0] text_length;
    } in_item_t;

    // Output transaction
    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               end_of_text;
        logic [CNT13_W-1:0] replacement_count;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // take input transaction
        logic emit_cur;   // emit held input byte (replacing stopped)
        logic pop;        // emit oldest pending byte
        logic set_stop;   // capacity check failed
        logic emit_repl;  // emit next replacement byte
        logic commit;     // match replaced: drop window, count it
        logic fin;        // close out the item
    } sfr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic text_ended;
        logic in_zero;
        logic stopped;
        logic mismatch;
        logic match_ready;
        logic over_cap;
        logic repl_zero;
        logic repl_done;
        logic pend_empty;
        logic hold_valid;
        logic emit_ok;
        logic push_ok;
        logic ending;
    } sfr_status_t;

endpackage

`default_nettype wire

// ===== sv/sfr_ctrl.sv =====
// sfr_ctrl: per-item sequencer for the stream find-and-replace block.
// Walks each input transaction through check, replace and flush steps.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sfr_pkg::sfr_status_t status,
    output sfr_pkg::sfr_cmd_t    cmd
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMITB,
        S_CHECK,
        S_REPL,
        S_FLUSH,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    priority if (status.text_ended)
                        state_next = S_IDLE;
                    else if (status.in_zero)
                        state_next = S_FLUSH;
                    else if (status.stopped)
                        state_next = S_EMITB;
                    else
                        state_next = S_CHECK;
                end
            end
            S_EMITB:
            begin
                if (status.emit_ok)
                begin
                    cmd.emit_cur = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_CHECK:
            begin
                priority if (status.mismatch)
                begin
                    cmd.pop = status.emit_ok;
                end
                else if (status.match_ready)
                begin
                    priority if (status.over_cap)
                    begin
                        cmd.set_stop = 1'b1;
                        state_next   = S_FLUSH;
                    end
                    else if (status.repl_zero)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else
                        state_next = S_REPL;
                end
                else
                    state_next = S_FLUSH;
            end
            S_REPL:
            begin
                if (status.emit_ok)
                begin
                    cmd.emit_repl = 1'b1;
                    if (status.repl_done)
                    begin
                        cmd.commit = 1'b1;
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!status.pend_empty && (status.ending || status.stopped))
                    cmd.pop = status.emit_ok;
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!(status.hold_valid || status.ending) || status.push_ok)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== sv/sfr_datapath.sv =====
// sfr_datapath: configuration registers, pending window, counters, hold
// stage and output register of the stream find-and-replace block.
// Depends on sfr_pkg; driven by sfr_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module sfr_datapath #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  sfr_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sfr_pkg::out_item_t                  out_data,
    input  sfr_pkg::sfr_cmd_t                   cmd,
    output sfr_pkg::sfr_status_t                status
);
    import sfr_pkg::*;

    localparam int WIN_W = 8 * MAX_PATTERN;
    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    // Configuration
    logic [63:0]      pat_bytes_reg, pat_bytes_next;
    logic [3:0]       pat_len_reg, pat_len_next;
    logic [63:0]      rep_bytes_reg, rep_bytes_next;
    logic [3:0]       rep_len_reg, rep_len_next;
    logic [CAP_W-1:0] capacity_reg, capacity_next;

    // Per-text state
    logic [WIN_W-1:0]   win_reg, win_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT13_W-1:0] consumed_reg, consumed_next;
    logic [CAP_W-1:0]   emitted_reg, emitted_next;
    logic [CNT13_W-1:0] match_reg, match_next;
    logic               stopped_reg, stopped_next;
    logic               ended_reg, ended_next;
    logic [2:0]         idx_reg, idx_next;

    // Current item, hold stage, output register
    logic [7:0]         cur_byte_reg, cur_byte_next;
    logic               cur_last_reg, cur_last_next;
    logic [CNT13_W-1:0] cur_tlen_reg, cur_tlen_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [7:0]         hold_byte_reg, hold_byte_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    // Derived values
    logic [3:0]         plen_clamp;
    logic [CNT_W-1:0]   plen_eff;
    logic [3:0]         rlen_eff;
    logic               mismatch;
    logic [CNT13_W-1:0] tail;
    logic [CAP_W:0]     proj;
    logic               can_push;
    logic               ending;
    logic               emit_any;
    logic [7:0]         emit_byte;

    // Length clamps
    always_comb
    begin
        priority if (pat_len_reg == 4'd0)
            plen_clamp = 4'd1;
        else if (pat_len_reg > 4'(MAX_PATTERN))
            plen_clamp = 4'(MAX_PATTERN);
        else
            plen_clamp = pat_len_reg;
        plen_eff = plen_clamp[CNT_W-1:0];
        rlen_eff = (rep_len_reg > 4'(REPL_MAX)) ? 4'(REPL_MAX) : rep_len_reg;
    end

    // Pending bytes against the pattern prefix, lane by lane
    always_comb
    begin
        mismatch = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((CNT_W'(i) < cnt_reg) && (win_reg[8*i +: 8] != pat_bytes_reg[8*i +: 8]))
                mismatch = 1'b1;
        end
    end

    // Projected length check
    always_comb
    begin
        tail = (cur_tlen_reg > consumed_reg) ? (cur_tlen_reg - consumed_reg) : '0;
        proj = {1'b0, emitted_reg} + (CAP_W + 1)'(rlen_eff) + (CAP_W + 1)'(tail);
    end

    assign can_push  = !out_valid_reg || out_ready;
    assign ending    = cur_last_reg || (cur_byte_reg == 8'd0);
    assign emit_any  = cmd.emit_cur || cmd.pop || cmd.emit_repl;

    always_comb
    begin
        priority if (cmd.emit_cur)
            emit_byte = cur_byte_reg;
        else if (cmd.pop)
            emit_byte = win_reg[7:0];
        else
            emit_byte = rep_bytes_reg[8*idx_reg +: 8];
    end

    // Status to the controller
    always_comb
    begin
        status.text_ended  = ended_reg;
        status.in_zero     = (in_data.data_byte == 8'd0);
        status.stopped     = stopped_reg;
        status.mismatch    = mismatch;
        status.match_ready = (cnt_reg >= plen_eff);
        status.over_cap    = (proj >= {1'b0, capacity_reg});
        status.repl_zero   = (rlen_eff == 4'd0);
        status.repl_done   = ({1'b0, idx_reg} == (rlen_eff - 4'd1));
        status.pend_empty  = (cnt_reg == '0);
        status.hold_valid  = hold_valid_reg;
        status.emit_ok     = !hold_valid_reg || can_push;
        status.push_ok     = can_push;
        status.ending      = ending;
    end

    // Next-state logic
    always_comb
    begin
        pat_bytes_next  = pat_bytes_reg;
        pat_len_next    = pat_len_reg;
        rep_bytes_next  = rep_bytes_reg;
        rep_len_next    = rep_len_reg;
        capacity_next   = capacity_reg;
        win_next        = win_reg;
        cnt_next        = cnt_reg;
        consumed_next   = consumed_reg;
        emitted_next    = emitted_reg;
        match_next      = match_reg;
        stopped_next    = stopped_reg;
        ended_next      = ended_reg;
        idx_next        = idx_reg;
        cur_byte_next   = cur_byte_reg;
        cur_last_next   = cur_last_reg;
        cur_tlen_next   = cur_tlen_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        // Register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_BYTES:      pat_bytes_next = cfg_data;
                REG_PATTERN_LENGTH:     pat_len_next   = cfg_data[3:0];
                REG_REPLACEMENT_BYTES:  rep_bytes_next = cfg_data;
                REG_REPLACEMENT_LENGTH: rep_len_next   = cfg_data[3:0];
                REG_CAPACITY:           capacity_next  = cfg_data[CAP_W-1:0];
                default:                ;
            endcase
        end

        // Take an item: count a nonzero byte, window it unless stopped
        if (cmd.load)
        begin
            cur_byte_next = in_data.data_byte;
            cur_last_next = in_data.last;
            cur_tlen_next = in_data.text_length;
            idx_next      = '0;
            if (ended_reg)
            begin
                if (in_data.last)
                begin
                    ended_next    = 1'b0;
                    win_next      = '0;
                    cnt_next      = '0;
                    consumed_next = '0;
                    emitted_next  = '0;
                    match_next    = '0;
                    stopped_next  = 1'b0;
                end
            end
            else if (in_data.data_byte != 8'd0)
            begin
                if (consumed_reg != '1)
                    consumed_next = consumed_reg + 1'b1;
                if (!stopped_reg)
                begin
                    for (int i = 0; i < MAX_PATTERN; i++)
                    begin
                        if (cnt_reg == CNT_W'(i))
                            win_next[8*i +: 8] = in_data.data_byte;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        end

        // Emit one byte through the hold stage
        if (emit_any)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next                  = 1'b1;
                out_data_next.out_byte          = hold_byte_reg;
                out_data_next.byte_valid        = 1'b1;
                out_data_next.end_of_text       = 1'b0;
                out_data_next.replacement_count = '0;
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = emit_byte;
            if (emitted_reg != '1)
                emitted_next = emitted_reg + 1'b1;
        end

        if (cmd.pop)
        begin
            win_next = win_reg >> 8;
            cnt_next = cnt_reg - 1'b1;
        end

        if (cmd.emit_repl)
            idx_next = idx_reg + 1'b1;

        if (cmd.commit)
        begin
            win_next = '0;
            cnt_next = '0;
            if (match_reg != '1)
                match_next = match_reg + 1'b1;
        end

        if (cmd.set_stop)
            stopped_next = 1'b1;

        // Close the item: last held byte or an empty closing result
        if (cmd.fin)
        begin
            if (hold_valid_reg || ending)
            begin
                out_valid_next                  = 1'b1;
                out_data_next.out_byte          = hold_valid_reg ? hold_byte_reg : 8'd0;
                out_data_next.byte_valid        = hold_valid_reg;
                out_data_next.end_of_text       = ending;
                out_data_next.replacement_count = ending ? match_reg : '0;
            end
            hold_valid_next = 1'b0;
            if (ending)
            begin
                win_next      = '0;
                cnt_next      = '0;
                consumed_next = '0;
                emitted_next  = '0;
                match_next    = '0;
                stopped_next  = 1'b0;
                ended_next    = !cur_last_reg;
            end
        end
    end

    // Control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg  <= '0;
            pat_len_reg    <= 4'd1;
            rep_bytes_reg  <= '0;
            rep_len_reg    <= '0;
            capacity_reg   <= MAX_TEXT;
            win_reg        <= '0;
            cnt_reg        <= '0;
            consumed_reg   <= '0;
            emitted_reg    <= '0;
            match_reg      <= '0;
            stopped_reg    <= 1'b0;
            ended_reg      <= 1'b0;
            idx_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pat_bytes_reg  <= pat_bytes_next;
            pat_len_reg    <= pat_len_next;
            rep_bytes_reg  <= rep_bytes_next;
            rep_len_reg    <= rep_len_next;
            capacity_reg   <= capacity_next;
            win_reg        <= win_next;
            cnt_reg        <= cnt_next;
            consumed_reg   <= consumed_next;
            emitted_reg    <= emitted_next;
            match_reg      <= match_next;
            stopped_reg    <= stopped_next;
            ended_reg      <= ended_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_byte_reg  <= cur_byte_next;
        cur_last_reg  <= cur_last_next;
        cur_tlen_reg  <= cur_tlen_next;
        hold_byte_reg <= hold_byte_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/stream_find_replace_top.sv =====
// stream_find_replace_top: top level of the streaming find-and-replace block.
// Instantiates sfr_ctrl and sfr_datapath; depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Text bytes come in one transaction at a time; every leftmost,
// non-overlapping occurrence of the pattern (1 to MAX_PATTERN bytes) is
// replaced by the replacement (0 to 8 bytes), one output transaction per
// byte. A zero byte or last ends the text; its final output transaction has
// end_of_text set and carries replacement_count, and is an empty result
// (byte_valid low) if no byte is left. The controller works one item at a
// time: it loads and checks it, replaces on a match, then flushes and closes
// it; a byte after replacing has stopped is just emitted and closed, a zero
// byte flushes held bytes before closing, and items after an early zero byte
// are dropped. Emitted bytes go one per cycle through a one-byte hold stage
// into the output register, so output backpressure stretches the emit steps.
// Configuration must be written by the user via cfg_we/cfg_index/cfg_data
// while the block is idle; the block itself does not enforce this.
module stream_find_replace_top #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sfr_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output sfr_pkg::out_item_t             out_data
);
    import sfr_pkg::*;

    sfr_cmd_t    cmd;
    sfr_status_t status;

    sfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sfr_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

    // An empty result only ever closes a text
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.end_of_text)
        else $error("empty result without end_of_text");

    // Count is reported only on the closing result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.end_of_text |-> out_data.replacement_count == '0)
        else $error("replacement_count outside end_of_text");

    // At most one byte source per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_cur, cmd.pop, cmd.emit_repl}))
        else $error("conflicting emit commands");

    // Hold stage is drained before a new transaction is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !status.hold_valid)
        else $error("hold stage busy while ready");

endmodule

`default_nettype wire
